// File: rtl/core/tcca_pkg.sv
// Shared constants and controller/datapath interface types for the clip aggregator.
package tcca_pkg;

    localparam int MAX_COUNT = 32;
    localparam int MAX_WIDTH = 16;
    localparam int STORE_CAP = MAX_COUNT * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(STORE_CAP);
    localparam int LD_W      = $clog2(STORE_CAP + 1);
    localparam int VEC_W     = $clog2(MAX_COUNT);
    localparam int DEN_W     = $clog2(MAX_COUNT + 1);
    localparam int DATA_W    = 64;
    localparam int COORD_W   = 4;
    localparam int VW_W      = 5;
    localparam int TRIM_W    = 5;
    localparam int ITER_W    = 16;
    localparam int Q_W       = 63;
    localparam int STAT_W    = 2;
    localparam int CIDX_W    = 8;

    localparam logic [DATA_W-1:0] NORM_LIMIT = 64'd3037000499;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_QBOUND = 2'd1,
        STAT_OVF    = 2'd2,
        STAT_BAD    = 2'd3
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_VECTOR_WIDTH = 8'd0,
        CFG_TRIM_COUNT   = 8'd1,
        CFG_ITER_COUNT   = 8'd2,
        CFG_MAX_ABS_Q    = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic               val_we;
        logic               val_re;
        logic [ADDR_W-1:0]  val_addr;
        logic               norm_mul;
        logic               norm_acc;
        logic               norm_we;
        logic               norm_re;
        logic [VEC_W-1:0]   vec_idx;
        logic               best_clr;
        logic               best_upd;
        logic               dev_we;
        logic               dev_re;
        logic [ADDR_W-1:0]  dev_addr;
        logic               sel_init;
        logic               sel_cnt;
        logic               sel_bit;
        logic [LD_W-1:0]    sel_k;
        logic               col_d;
        logic               col_s;
        logic               col_sum;
        logic               sum_clr;
        logic               div_start;
        logic               rnd;
        logic               c_clr;
        logic               c_we;
        logic [COORD_W-1:0] coord;
        logic               out_zero;
        logic [DEN_W-1:0]   den;
    } cmd_t;

    typedef struct packed {
        logic bnd_fail;
        logic nrm_big;
        logic nrm_ovf;
        logic take;
        logic dev_ovf;
        logic sel_last;
        logic rad_ovf;
        logic s_ovf;
        logic sum_ovf;
        logic div_done;
        logic div_ovf;
        logic c_same;
    } stat_t;

endpackage

// File: rtl/core/trimmed_centered_clip_aggregator_unit.sv
// Top level: configuration registers, controller and datapath of the clip aggregator.
// Coordinates load at one request per cycle into a 512-entry store, in vector order, until
// the request flagged last_in_set. Input then stalls while the set is processed: a vector
// count by repeated subtraction, bound check and norm per vector, a scan per trimmed
// vector, and per clipping round nd deviation writes, 64 select passes over the
// deviation memory (nd = accepted * vw; this median search dominates), and per coordinate
// a column pass over the accepted vectors plus the 64-step divider. Rounds stop early at
// a fixed point. The results then stream out, one per cycle while m_ready is high: vw
// coordinates, or one status result on error. No clearing pass is needed after reset.
module trimmed_centered_clip_aggregator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcca_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [tcca_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcca_pkg::DATA_W-1:0]   s_q_value,
    input  logic                          s_last_in_set,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcca_pkg::DATA_W-1:0]   m_center_value,
    output logic [tcca_pkg::COORD_W-1:0]  m_coord_index,
    output logic [tcca_pkg::STAT_W-1:0]   m_status,
    output logic                          m_last_result
);
    import tcca_pkg::*;

    logic [VW_W-1:0]   vw_reg;
    logic [TRIM_W-1:0] trim_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [Q_W-1:0]    maxq_reg;
    cmd_t              cmd;
    stat_t             st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg   <= VW_W'(1);
            trim_reg <= '0;
            iter_reg <= ITER_W'(1);
            maxq_reg <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VECTOR_WIDTH: vw_reg   <= cfg_data[VW_W-1:0];
                CFG_TRIM_COUNT:   trim_reg <= cfg_data[TRIM_W-1:0];
                CFG_ITER_COUNT:   iter_reg <= cfg_data[ITER_W-1:0];
                CFG_MAX_ABS_Q:    maxq_reg <= cfg_data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    tcca_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_vw        (vw_reg),
        .cfg_trim      (trim_reg),
        .cfg_iter      (iter_reg),
        .cfg_q_zero    (maxq_reg == '0),
        .s_valid       (s_valid),
        .s_last_in_set (s_last_in_set),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coord_index (m_coord_index),
        .m_status      (m_status),
        .m_last_result (m_last_result),
        .cmd           (cmd),
        .st            (st)
    );

    tcca_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_max_abs_q (maxq_reg),
        .s_q_value     (s_q_value),
        .st            (st),
        .out_value     (m_center_value)
    );

    // input is held off for the whole compute and drain of a set
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while results pending");

    // an error result is a lone zero result
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |->
            (m_center_value == '0 && m_last_result && m_coord_index == '0))
        else $error("malformed error result");

    // after the final result the block goes back to loading
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> (s_ready && !m_valid))
        else $error("block did not return to loading");

endmodule

// File: rtl/core/tcca_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module tcca_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tcca_pkg::DATA_W-1:0] dividend,
    input  logic [tcca_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [tcca_pkg::DATA_W-1:0] quotient,
    output logic [tcca_pkg::DEN_W-1:0]  remainder
);
    import tcca_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    shifted;
    logic              ge;

    assign shifted = {rem_reg, dvd_reg[DATA_W-1]};
    assign ge      = shifted >= {1'b0, divisor};

    always_comb begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            quo_next = {quo_reg[DATA_W-2:0], ge};
            rem_next = ge ? DEN_W'(shifted - {1'b0, divisor}) : DEN_W'(shifted);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/tcca_dp.sv
// Datapath: coordinate, norm and deviation memories, norm, select and clipping arithmetic.
module tcca_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tcca_pkg::cmd_t              cmd,
    input  logic [tcca_pkg::Q_W-1:0]    cfg_max_abs_q,
    input  logic [tcca_pkg::DATA_W-1:0] s_q_value,
    output tcca_pkg::stat_t             st,
    output logic [tcca_pkg::DATA_W-1:0] out_value
);
    import tcca_pkg::*;

    localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    logic [DATA_W-1:0] val_mem [STORE_CAP];
    logic [DATA_W-1:0] dev_mem [STORE_CAP];
    logic [DATA_W-1:0] norm_mem [MAX_COUNT];
    logic [DATA_W-1:0] c_reg [MAX_WIDTH];

    logic [DATA_W-1:0] val_rd_reg, dev_rd_reg, norm_rd_reg;
    logic [DATA_W-1:0] prod_reg, total_reg, best_norm_reg;
    logic              best_v_reg;
    logic [DATA_W-1:0] p_reg, hmask_reg, bsel_reg;
    logic [LD_W-1:0]   k_reg, cnt0_reg;
    logic [DATA_W-1:0] dcl_reg, s_reg, sum_reg, rnd_reg;

    logic [DATA_W-1:0] vmag, c_cur, d_val, neg_r, dcl;
    logic [DATA_W:0]   acc65, d65, s65, sum65;
    logic              match;
    logic              div_done;
    logic [DATA_W-1:0] quo;
    logic [DEN_W-1:0]  rem, half_gap;
    logic              up;
    logic [DATA_W-1:0] q_up, rnd_val;

    // memories: one address per port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.val_we) val_mem[cmd.val_addr] <= s_q_value;
        if (cmd.val_re) val_rd_reg <= val_mem[cmd.val_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.dev_we) dev_mem[cmd.dev_addr] <= mag64(d_val);
        if (cmd.dev_re) dev_rd_reg <= dev_mem[cmd.dev_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm_we) norm_mem[cmd.vec_idx] <= acc65[DATA_W-1:0];
        if (cmd.norm_re) norm_rd_reg <= norm_mem[cmd.vec_idx];
    end

    // squared norm
    assign vmag  = mag64(val_rd_reg);
    assign acc65 = {1'b0, total_reg} + {1'b0, prod_reg};

    always_ff @(posedge aclk) begin
        if (cmd.norm_mul) prod_reg <= vmag[31:0] * vmag[31:0];
        if (cmd.c_clr || cmd.norm_we) begin
            total_reg <= '0;
        end else if (cmd.norm_acc) begin
            total_reg <= acc65[DATA_W-1:0];
        end
    end

    // trim scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_v_reg <= 1'b0;
        end else if (cmd.best_clr) begin
            best_v_reg <= 1'b0;
        end else if (cmd.best_upd) begin
            best_v_reg <= 1'b1;
        end
        if (cmd.best_upd) best_norm_reg <= norm_rd_reg;
    end

    // centers
    assign c_cur = c_reg[cmd.coord];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.c_clr) begin
            for (int n = 0; n < MAX_WIDTH; n++) begin
                c_reg[n] <= '0;
            end
        end else if (cmd.c_we) begin
            c_reg[cmd.coord] <= rnd_reg;
        end
    end

    // difference from center, shared by deviation and column passes
    assign d65   = {val_rd_reg[DATA_W-1], val_rd_reg} - {c_cur[DATA_W-1], c_cur};
    assign d_val = d65[DATA_W-1:0];

    // radix select of the upper median, one bit per pass
    assign match = (((dev_rd_reg ^ p_reg) & hmask_reg) == '0) && ((dev_rd_reg & bsel_reg) == '0);

    always_ff @(posedge aclk) begin
        if (cmd.sel_init) begin
            p_reg     <= '0;
            hmask_reg <= '0;
            bsel_reg  <= INT_MIN;
            k_reg     <= cmd.sel_k;
            cnt0_reg  <= '0;
        end else if (cmd.sel_cnt) begin
            if (match) cnt0_reg <= cnt0_reg + LD_W'(1);
        end else if (cmd.sel_bit) begin
            if (k_reg >= cnt0_reg) begin
                k_reg <= k_reg - cnt0_reg;
                p_reg <= p_reg | bsel_reg;
            end
            hmask_reg <= hmask_reg | bsel_reg;
            bsel_reg  <= bsel_reg >> 1;
            cnt0_reg  <= '0;
        end
    end

    // clipping column
    assign neg_r = ~p_reg + DATA_W'(1);

    always_comb begin
        if ($signed(d_val) > $signed(p_reg)) begin
            dcl = p_reg;
        end else if ($signed(d_val) < $signed(neg_r)) begin
            dcl = neg_r;
        end else begin
            dcl = d_val;
        end
    end

    assign s65   = {c_cur[DATA_W-1], c_cur} + {dcl_reg[DATA_W-1], dcl_reg};
    assign sum65 = {sum_reg[DATA_W-1], sum_reg} + {s_reg[DATA_W-1], s_reg};

    always_ff @(posedge aclk) begin
        if (cmd.col_d) dcl_reg <= dcl;
        if (cmd.col_s) s_reg <= s65[DATA_W-1:0];
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.col_sum) begin
            sum_reg <= sum65[DATA_W-1:0];
        end
        if (cmd.rnd) rnd_reg <= rnd_val;
    end

    tcca_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag64(sum_reg)),
        .divisor   (cmd.den),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // round half up on the signed quotient
    assign half_gap = cmd.den - rem;
    assign up       = sum_reg[DATA_W-1] ? ((rem != '0) && (rem > half_gap)) : (rem >= half_gap);
    assign q_up     = quo + DATA_W'(up);
    assign rnd_val  = sum_reg[DATA_W-1] ? (~q_up + DATA_W'(1)) : q_up;

    assign st.bnd_fail = vmag > {1'b0, cfg_max_abs_q};
    assign st.nrm_big  = vmag > NORM_LIMIT;
    assign st.nrm_ovf  = acc65[DATA_W] | acc65[DATA_W-1];
    assign st.take     = !best_v_reg || (norm_rd_reg >= best_norm_reg);
    assign st.dev_ovf  = (c_cur == INT_MIN) || (d65[DATA_W] != d65[DATA_W-1]);
    assign st.sel_last = bsel_reg[0];
    assign st.rad_ovf  = p_reg[DATA_W-1];
    assign st.s_ovf    = s65[DATA_W] != s65[DATA_W-1];
    assign st.sum_ovf  = sum65[DATA_W] != sum65[DATA_W-1];
    assign st.div_done = div_done;
    assign st.div_ovf  = quo[DATA_W-1];
    assign st.c_same   = rnd_reg == c_cur;

    assign out_value = cmd.out_zero ? '0 : c_cur;

endmodule

// File: rtl/core/tcca_ctrl.sv
// Controller: load, checks, norm, trim, clipping rounds and result sequencing.
module tcca_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [tcca_pkg::VW_W-1:0]    cfg_vw,
    input  logic [tcca_pkg::TRIM_W-1:0]  cfg_trim,
    input  logic [tcca_pkg::ITER_W-1:0]  cfg_iter,
    input  logic                         cfg_q_zero,
    input  logic                         s_valid,
    input  logic                         s_last_in_set,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcca_pkg::COORD_W-1:0] m_coord_index,
    output logic [tcca_pkg::STAT_W-1:0]  m_status,
    output logic                         m_last_result,
    output tcca_pkg::cmd_t               cmd,
    input  tcca_pkg::stat_t              st
);
    import tcca_pkg::*;

    typedef enum logic [27:0] {
        ST_LOAD     = 28'h0000001,
        ST_CHECK    = 28'h0000002,
        ST_DIVN     = 28'h0000004,
        ST_BND_RD   = 28'h0000008,
        ST_BND_CHK  = 28'h0000010,
        ST_NRM_RD   = 28'h0000020,
        ST_NRM_MUL  = 28'h0000040,
        ST_NRM_ACC  = 28'h0000080,
        ST_TRM_RD   = 28'h0000100,
        ST_TRM_CMP  = 28'h0000200,
        ST_TRM_MARK = 28'h0000400,
        ST_DEV_RD   = 28'h0000800,
        ST_DEV_WR   = 28'h0001000,
        ST_SEL_INIT = 28'h0002000,
        ST_SEL_RD   = 28'h0004000,
        ST_SEL_CNT  = 28'h0008000,
        ST_SEL_BIT  = 28'h0010000,
        ST_RAD      = 28'h0020000,
        ST_COL_RD   = 28'h0040000,
        ST_COL_D    = 28'h0080000,
        ST_COL_S    = 28'h0100000,
        ST_COL_SUM  = 28'h0200000,
        ST_DIV      = 28'h0400000,
        ST_DIV_WAIT = 28'h0800000,
        ST_RND      = 28'h1000000,
        ST_CWR      = 28'h2000000,
        ST_OUT      = 28'h4000000,
        ST_OUT_ERR  = 28'h8000000
    } state_t;

    state_t               state_reg, state_next;
    logic [LD_W-1:0]      ld_cnt_reg, ld_cnt_next;
    logic                 lost_reg, lost_next;
    logic [LD_W-1:0]      rem_reg, rem_next;
    logic [LD_W-1:0]      cnt_reg, cnt_next;
    logic [VEC_W-1:0]     i_reg, i_next;
    logic [COORD_W-1:0]   j_reg, j_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [TRIM_W-1:0]    t_reg, t_next;
    logic [MAX_COUNT-1:0] mask_reg, mask_next;
    logic [VEC_W-1:0]     best_reg, best_next;
    logic [LD_W-1:0]      nd_reg, nd_next;
    logic [LD_W-1:0]      e_reg, e_next;
    logic [ITER_W-1:0]    it_reg, it_next;
    logic                 same_reg, same_next;
    status_t              stat_reg, stat_next;

    logic last_vec, last_j, last_e, skip;

    assign last_vec = LD_W'(i_reg) == (cnt_reg - LD_W'(1));
    assign last_j   = {1'b0, j_reg} == (cfg_vw - VW_W'(1));
    assign last_e   = e_reg == (nd_reg - LD_W'(1));
    assign skip     = mask_reg[i_reg];

    always_comb begin
        state_next = state_reg;
        ld_cnt_next = ld_cnt_reg;
        lost_next = lost_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        base_next = base_reg;
        t_next = t_reg;
        mask_next = mask_reg;
        best_next = best_reg;
        nd_next = nd_reg;
        e_next = e_reg;
        it_next = it_reg;
        same_next = same_reg;
        stat_next = stat_reg;

        cmd          = '0;
        cmd.val_addr = base_reg + ADDR_W'(j_reg);
        cmd.vec_idx  = i_reg;
        cmd.dev_addr = nd_reg[ADDR_W-1:0];
        cmd.sel_k    = nd_reg >> 1;
        cmd.coord    = j_reg;
        cmd.den      = DEN_W'(cnt_reg - LD_W'(cfg_trim));

        s_ready = 1'b0;
        m_valid = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready      = 1'b1;
                cmd.val_addr = ld_cnt_reg[ADDR_W-1:0];
                if (s_valid) begin
                    if (ld_cnt_reg < LD_W'(STORE_CAP)) begin
                        cmd.val_we  = 1'b1;
                        ld_cnt_next = ld_cnt_reg + LD_W'(1);
                    end else begin
                        lost_next = 1'b1;
                    end
                    if (s_last_in_set) state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.c_clr   = 1'b1;
                ld_cnt_next = '0;
                lost_next   = 1'b0;
                mask_next   = '0;
                rem_next    = ld_cnt_reg;
                cnt_next    = '0;
                if (lost_reg || cfg_vw == '0 || int'(cfg_vw) > MAX_WIDTH ||
                    cfg_iter == '0 || cfg_q_zero) begin
                    stat_next  = STAT_BAD;
                    state_next = ST_OUT_ERR;
                end else begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                // vector count by repeated subtraction
                if (rem_reg >= LD_W'(cfg_vw)) begin
                    rem_next = rem_reg - LD_W'(cfg_vw);
                    cnt_next = cnt_reg + LD_W'(1);
                end else if (rem_reg != '0 || cnt_reg == '0 ||
                             cnt_reg > LD_W'(MAX_COUNT) || LD_W'(cfg_trim) >= cnt_reg) begin
                    stat_next  = STAT_BAD;
                    state_next = ST_OUT_ERR;
                end else begin
                    i_next     = '0;
                    j_next     = '0;
                    base_next  = '0;
                    state_next = ST_BND_RD;
                end
            end
            ST_BND_RD: begin
                cmd.val_re = 1'b1;
                state_next = ST_BND_CHK;
            end
            ST_BND_CHK: begin
                if (st.bnd_fail) begin
                    stat_next  = STAT_QBOUND;
                    state_next = ST_OUT_ERR;
                end else if (last_j) begin
                    j_next     = '0;
                    state_next = ST_NRM_RD;
                end else begin
                    j_next     = j_reg + COORD_W'(1);
                    state_next = ST_BND_RD;
                end
            end
            ST_NRM_RD: begin
                cmd.val_re = 1'b1;
                state_next = ST_NRM_MUL;
            end
            ST_NRM_MUL: begin
                if (st.nrm_big) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.norm_mul = 1'b1;
                    state_next   = ST_NRM_ACC;
                end
            end
            ST_NRM_ACC: begin
                if (st.nrm_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.norm_acc = 1'b1;
                    if (last_j) begin
                        cmd.norm_we = 1'b1;
                        j_next      = '0;
                        if (last_vec) begin
                            i_next = '0;
                            t_next = '0;
                            if (cfg_trim == '0) begin
                                base_next  = '0;
                                nd_next    = '0;
                                it_next    = '0;
                                same_next  = 1'b1;
                                state_next = ST_DEV_RD;
                            end else begin
                                cmd.best_clr = 1'b1;
                                state_next   = ST_TRM_RD;
                            end
                        end else begin
                            i_next     = i_reg + VEC_W'(1);
                            base_next  = base_reg + ADDR_W'(cfg_vw);
                            state_next = ST_BND_RD;
                        end
                    end else begin
                        j_next     = j_reg + COORD_W'(1);
                        state_next = ST_NRM_RD;
                    end
                end
            end
            ST_TRM_RD: begin
                if (skip) begin
                    if (last_vec) state_next = ST_TRM_MARK;
                    else          i_next = i_reg + VEC_W'(1);
                end else begin
                    cmd.norm_re = 1'b1;
                    state_next  = ST_TRM_CMP;
                end
            end
            ST_TRM_CMP: begin
                // later vector wins a tie
                if (st.take) begin
                    cmd.best_upd = 1'b1;
                    best_next    = i_reg;
                end
                if (last_vec) begin
                    state_next = ST_TRM_MARK;
                end else begin
                    i_next     = i_reg + VEC_W'(1);
                    state_next = ST_TRM_RD;
                end
            end
            ST_TRM_MARK: begin
                mask_next[best_reg] = 1'b1;
                i_next = '0;
                if (t_reg == cfg_trim - TRIM_W'(1)) begin
                    base_next  = '0;
                    j_next     = '0;
                    nd_next    = '0;
                    it_next    = '0;
                    same_next  = 1'b1;
                    state_next = ST_DEV_RD;
                end else begin
                    t_next       = t_reg + TRIM_W'(1);
                    cmd.best_clr = 1'b1;
                    state_next   = ST_TRM_RD;
                end
            end
            ST_DEV_RD: begin
                if (skip) begin
                    if (last_vec) begin
                        state_next = ST_SEL_INIT;
                    end else begin
                        i_next    = i_reg + VEC_W'(1);
                        base_next = base_reg + ADDR_W'(cfg_vw);
                    end
                end else begin
                    cmd.val_re = 1'b1;
                    state_next = ST_DEV_WR;
                end
            end
            ST_DEV_WR: begin
                if (st.dev_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.dev_we = 1'b1;
                    nd_next    = nd_reg + LD_W'(1);
                    if (last_j) begin
                        j_next = '0;
                        if (last_vec) begin
                            state_next = ST_SEL_INIT;
                        end else begin
                            i_next     = i_reg + VEC_W'(1);
                            base_next  = base_reg + ADDR_W'(cfg_vw);
                            state_next = ST_DEV_RD;
                        end
                    end else begin
                        j_next     = j_reg + COORD_W'(1);
                        state_next = ST_DEV_RD;
                    end
                end
            end
            ST_SEL_INIT: begin
                cmd.sel_init = 1'b1;
                e_next       = '0;
                state_next   = ST_SEL_RD;
            end
            ST_SEL_RD: begin
                cmd.dev_re   = 1'b1;
                cmd.dev_addr = e_reg[ADDR_W-1:0];
                state_next   = ST_SEL_CNT;
            end
            ST_SEL_CNT: begin
                cmd.sel_cnt = 1'b1;
                if (last_e) begin
                    state_next = ST_SEL_BIT;
                end else begin
                    e_next     = e_reg + LD_W'(1);
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_BIT: begin
                cmd.sel_bit = 1'b1;
                e_next      = '0;
                state_next  = st.sel_last ? ST_RAD : ST_SEL_RD;
            end
            ST_RAD: begin
                if (st.rad_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    i_next      = '0;
                    j_next      = '0;
                    base_next   = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_COL_RD;
                end
            end
            ST_COL_RD: begin
                if (skip) begin
                    if (last_vec) begin
                        state_next = ST_DIV;
                    end else begin
                        i_next    = i_reg + VEC_W'(1);
                        base_next = base_reg + ADDR_W'(cfg_vw);
                    end
                end else begin
                    cmd.val_re = 1'b1;
                    state_next = ST_COL_D;
                end
            end
            ST_COL_D: begin
                if (st.dev_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.col_d  = 1'b1;
                    state_next = ST_COL_S;
                end
            end
            ST_COL_S: begin
                if (st.s_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.col_s  = 1'b1;
                    state_next = ST_COL_SUM;
                end
            end
            ST_COL_SUM: begin
                if (st.sum_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.col_sum = 1'b1;
                    if (last_vec) begin
                        state_next = ST_DIV;
                    end else begin
                        i_next     = i_reg + VEC_W'(1);
                        base_next  = base_reg + ADDR_W'(cfg_vw);
                        state_next = ST_COL_RD;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (st.div_done) state_next = ST_RND;
            end
            ST_RND: begin
                if (st.div_ovf) begin
                    stat_next  = STAT_OVF;
                    state_next = ST_OUT_ERR;
                end else begin
                    cmd.rnd    = 1'b1;
                    state_next = ST_CWR;
                end
            end
            ST_CWR: begin
                cmd.c_we  = 1'b1;
                same_next = same_reg && st.c_same;
                i_next    = '0;
                base_next = '0;
                if (last_j) begin
                    j_next = '0;
                    // a round that leaves the center unchanged is a fixed point
                    if ((same_reg && st.c_same) || it_reg == cfg_iter - ITER_W'(1)) begin
                        stat_next  = STAT_OK;
                        state_next = ST_OUT;
                    end else begin
                        it_next    = it_reg + ITER_W'(1);
                        nd_next    = '0;
                        same_next  = 1'b1;
                        state_next = ST_DEV_RD;
                    end
                end else begin
                    j_next      = j_reg + COORD_W'(1);
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_COL_RD;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (last_j) begin
                        j_next     = '0;
                        state_next = ST_LOAD;
                    end else begin
                        j_next = j_reg + COORD_W'(1);
                    end
                end
            end
            ST_OUT_ERR: begin
                m_valid      = 1'b1;
                cmd.out_zero = 1'b1;
                cmd.coord    = '0;
                if (m_ready) begin
                    j_next     = '0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            ld_cnt_reg <= '0;
            lost_reg   <= 1'b0;
            mask_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            base_reg   <= '0;
            t_reg      <= '0;
            nd_reg     <= '0;
            e_reg      <= '0;
            it_reg     <= '0;
            same_reg   <= 1'b1;
            stat_reg   <= STAT_OK;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            best_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            ld_cnt_reg <= ld_cnt_next;
            lost_reg   <= lost_next;
            mask_reg   <= mask_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            base_reg   <= base_next;
            t_reg      <= t_next;
            nd_reg     <= nd_next;
            e_reg      <= e_next;
            it_reg     <= it_next;
            same_reg   <= same_next;
            stat_reg   <= stat_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            best_reg   <= best_next;
        end
    end

    assign m_coord_index = (state_reg == ST_OUT_ERR) ? '0 : j_reg;
    assign m_status      = (state_reg == ST_OUT_ERR) ? stat_reg : STAT_OK;
    assign m_last_result = (state_reg == ST_OUT_ERR) || last_j;

endmodule

// File: bench/trimmed_centered_clip_aggregator_unit_tb.sv
// Self-checking bench for the trimmed centered-clip aggregator: directed sets, then random sets.
`timescale 1ns / 1ps

module trimmed_centered_clip_aggregator_unit_tb;
    import tcca_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 8'hA5;
    localparam longint I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'h8000_0000_0000_0000;

    typedef struct {
        longint       center;
        bit [3:0]     idx;
        status_t      st;
        bit           last;
    } center_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [DATA_W-1:0]   s_q_value;
    logic                s_last_in_set;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_center_value;
    logic [COORD_W-1:0]  m_coord_index;
    logic [STAT_W-1:0]   m_status;
    logic                m_last_result;

    // predictor state
    bit [4:0]        vw_r;
    bit [4:0]        trim_r;
    bit [15:0]       iter_r;
    bit [62:0]       qmax_r;
    longint          loaded_q[$];
    bit              store_full;
    center_result_t  center_q[$];

    int  errors;
    int  idle_cycles;
    int  items_sent;
    bit  no_idle;
    int  rx_gap;

    trimmed_centered_clip_aggregator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_q_value(s_q_value), .s_last_in_set(s_last_in_set),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_center_value(m_center_value), .m_coord_index(m_coord_index),
        .m_status(m_status), .m_last_result(m_last_result)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic bit [63:0] mag(longint v);
        bit [63:0] u;
        u = v;
        if (v < 0) u = -u;
        return u;
    endfunction

    function automatic bit add_ok(longint a, longint b, output longint r);
        r = a + b;
        return !((a[63] == b[63]) && (r[63] != a[63]));
    endfunction

    function automatic bit diff_ok(longint x, longint c, output longint r);
        if (c == I64_MIN) return 1'b0;
        return add_ok(x, -c, r);
    endfunction

    function automatic bit div_round(longint num, int den, output longint r);
        bit [63:0] m, q, rem, dd;
        dd = den;
        m = mag(num);
        q = m / dd;
        rem = m % dd;
        if (q[63]) return 1'b0;
        if (!num[63]) begin
            r = q + ((rem >= dd - rem) ? 64'd1 : 64'd0);
        end else begin
            r = -q;
            if (rem != 0 && rem > dd - rem) r -= 1;
        end
        return 1'b1;
    endfunction

    // whole-set computation: trim by norm, then centered clipping rounds
    function automatic status_t clip_aggregate(output longint ctr[MAX_WIDTH]);
        int n, w, cnt, acc, best;
        bit [63:0] norms[MAX_COUNT];
        bit rej[MAX_COUNT];
        bit [63:0] m, tot, radius;
        longint d, s, sum, r;
        longint nxt[MAX_WIDTH];
        bit [63:0] devs[$];
        bit same;
        for (int j = 0; j < MAX_WIDTH; j++) ctr[j] = 0;
        for (int i = 0; i < MAX_COUNT; i++) rej[i] = 1'b0;
        n = loaded_q.size();
        w = vw_r;
        if (store_full || w == 0 || w > 16 || w > MAX_WIDTH || iter_r == 0 || qmax_r == 0)
            return STAT_BAD;
        if (n % w != 0) return STAT_BAD;
        cnt = n / w;
        if (cnt == 0 || cnt > MAX_COUNT || trim_r >= cnt) return STAT_BAD;
        for (int i = 0; i < cnt; i++) begin
            for (int j = 0; j < w; j++)
                if (mag(loaded_q[i*w+j]) > {1'b0, qmax_r}) return STAT_QBOUND;
            tot = 0;
            for (int j = 0; j < w; j++) begin
                m = mag(loaded_q[i*w+j]);
                if (m > NORM_LIMIT) return STAT_OVF;
                tot += m * m;
                if (tot[63]) return STAT_OVF;
            end
            norms[i] = tot;
        end
        // ties go to the later vector
        for (int t = 0; t < trim_r; t++) begin
            best = cnt;
            for (int i = 0; i < cnt; i++) begin
                if (rej[i]) continue;
                if (best == cnt || norms[i] >= norms[best]) best = i;
            end
            if (best < cnt) rej[best] = 1'b1;
        end
        acc = cnt - trim_r;
        for (int it = 0; it < iter_r; it++) begin
            devs.delete();
            for (int i = 0; i < cnt; i++) begin
                if (rej[i]) continue;
                for (int j = 0; j < w; j++) begin
                    if (!diff_ok(loaded_q[i*w+j], ctr[j], d)) return STAT_OVF;
                    devs = {devs, mag(d)};
                end
            end
            devs.sort();
            radius = devs[devs.size() / 2];
            if (radius[63]) return STAT_OVF;
            r = radius;
            same = 1'b1;
            for (int j = 0; j < w; j++) begin
                sum = 0;
                for (int i = 0; i < cnt; i++) begin
                    if (rej[i]) continue;
                    if (!diff_ok(loaded_q[i*w+j], ctr[j], d)) return STAT_OVF;
                    if (d > r) d = r;
                    if (d < -r) d = -r;
                    if (!add_ok(ctr[j], d, s)) return STAT_OVF;
                    if (!add_ok(sum, s, sum)) return STAT_OVF;
                end
                if (!div_round(sum, acc, nxt[j])) return STAT_OVF;
                if (nxt[j] != ctr[j]) same = 1'b0;
            end
            for (int j = 0; j < w; j++) ctr[j] = nxt[j];
            if (same) break;
        end
        return STAT_OK;
    endfunction

    function automatic void predict_item(longint q, bit last);
        longint ctr[MAX_WIDTH];
        status_t st;
        center_result_t e;
        if (loaded_q.size() < STORE_CAP) loaded_q = {loaded_q, q};
        else store_full = 1'b1;
        if (!last) return;
        st = clip_aggregate(ctr);
        if (st != STAT_OK) begin
            e.center = 0; e.idx = 0; e.st = st; e.last = 1'b1;
            center_q = {center_q, e};
        end else begin
            for (int j = 0; j < vw_r; j++) begin
                e.center = ctr[j]; e.idx = j; e.st = STAT_OK; e.last = (j + 1 == vw_r);
                center_q = {center_q, e};
            end
        end
        loaded_q.delete();
        store_full = 1'b0;
    endfunction

    task automatic wait_idle();
        while (center_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_VECTOR_WIDTH: vw_r   = data[4:0];
            CFG_TRIM_COUNT:   trim_r = data[4:0];
            CFG_ITER_COUNT:   iter_r = data[15:0];
            CFG_MAX_ABS_Q:    qmax_r = data[62:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // upper bits beyond each register's width are junk on purpose
    task automatic set_regs(int w, int t, int it, logic [63:0] q);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_VECTOR_WIDTH, {junk[63:5], 5'(w)});
        write_reg(CFG_TRIM_COUNT, {junk[63:5], 5'(t)});
        write_reg(CFG_ITER_COUNT, {junk[63:16], 16'(it)});
        write_reg(CFG_MAX_ABS_Q, {junk[63], q[62:0]});
    endtask

    task automatic send_item(longint q, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_q_value     <= q;
        s_last_in_set <= last;
        do @(posedge aclk); while (!s_ready);
        predict_item(q, last);
        items_sent++;
        if (last) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic send_set(longint v[$]);
        no_idle = ($urandom_range(0, 3) == 0);
        foreach (v[i]) send_item(v[i], i == v.size() - 1);
    endtask

    function automatic longint rand_coord(int spread);
        case ($urandom_range(0, 11))
            0: return {$urandom, $urandom};
            1: begin
                case ($urandom_range(0, 6))
                    0: return I64_MIN;
                    1: return I64_MAX;
                    2: return NORM_LIMIT;
                    3: return -longint'(NORM_LIMIT);
                    4: return NORM_LIMIT + 1;
                    5: return -1;
                    default: return 0;
                endcase
            end
            default: return longint'($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    task automatic test_reset_defaults();
        longint v[$];
        v = '{longint'(5)};
        send_set(v);
        v = '{I64_MIN};
        send_set(v);
        v = '{-longint'(NORM_LIMIT)};
        send_set(v);
    endtask

    task automatic test_rounding_and_trim();
        longint v[$];
        // half-way averages: +1.5 rounds up, -1.5 rounds toward zero
        set_regs(1, 0, 1, I64_MAX);
        v = '{1, 2};
        send_set(v);
        v = '{-1, -2};
        send_set(v);
        // equal norms: the later vector is dropped
        set_regs(2, 1, 3, I64_MAX);
        v = '{3, 4, -4, 3, 0, 1};
        send_set(v);
        set_regs(2, 2, 5, 100);
        v = '{10, -7, 9, 9, -100, 0, 7, 7};
        send_set(v);
    endtask

    task automatic test_bound_and_overflow();
        longint v[$];
        set_regs(2, 0, 2, 50);
        v = '{50, -50, 51, 0};
        send_set(v);
        set_regs(2, 0, 2, I64_MAX);
        v = '{NORM_LIMIT + 1, 0};
        send_set(v);
        v = '{NORM_LIMIT, NORM_LIMIT};
        send_set(v);
        v = '{NORM_LIMIT, -longint'(NORM_LIMIT)};
        set_regs(1, 0, 4, I64_MAX);
        send_set(v);
    endtask

    task automatic test_bad_settings();
        longint v[$];
        v = '{1, 2, 3};
        set_regs(2, 0, 1, I64_MAX);
        send_set(v);
        set_regs(1, 3, 1, I64_MAX);
        send_set(v);
        set_regs(0, 0, 1, I64_MAX);
        send_set(v);
        set_regs(17, 0, 1, I64_MAX);
        send_set(v);
        set_regs(1, 0, 0, I64_MAX);
        send_set(v);
        set_regs(1, 0, 1, 0);
        send_set(v);
        // an unmapped index must leave the registers alone
        set_regs(1, 0, 1, I64_MAX);
        write_reg(CFG_UNUSED, '1);
        send_set(v);
    endtask

    task automatic test_long_iterations();
        longint v[$];
        set_regs(3, 0, 65535, I64_MAX);
        v = '{-1000, 2, 999};
        send_set(v);
        set_regs(1, 31, 2, I64_MAX);
        v = '{};
        for (int i = 0; i < MAX_COUNT; i++) v = {v, longint'(i) - 16};
        send_set(v);
    endtask

    task automatic test_random_sets();
        longint v[$];
        int w, cnt, t, it, n, spread;
        logic [63:0] q;
        while (items_sent < 160) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 3);
            cnt = (w > 4) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            t = (cnt > 1) ? $urandom_range(0, cnt - 1) : 0;
            if ($urandom_range(0, 14) == 0) t = $urandom_range(0, 31);
            it = $urandom_range(1, 4);
            spread = ($urandom_range(0, 1) == 0) ? 20 : 100000;
            case ($urandom_range(0, 5))
                0: q = $urandom_range(1, 2 * spread);
                1: q = {$urandom, $urandom};
                default: q = I64_MAX;
            endcase
            if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 31);
            set_regs(w, t, it, q);
            n = cnt * ((w == 0) ? 1 : w);
            if ($urandom_range(0, 9) == 0) n = (n > 1 && $urandom_range(0, 1)) ? n - 1 : n + 1;
            v = '{};
            for (int i = 0; i < n; i++) v = {v, rand_coord(spread)};
            send_set(v);
        end
    endtask

    // result side: random back-pressure and in-order checks
    initial begin
        center_result_t e;
        m_ready = 1'b0;
        rx_gap = 0;
        forever begin
            @(negedge aclk);
            m_ready <= (rx_gap == 0);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (center_q.size() == 0) begin
                    $display("%0t: unexpected result center=%0d idx=%0d", $realtime,
                             $signed(m_center_value), m_coord_index);
                    errors++;
                end else begin
                    e = center_q.pop_front();
                    if (m_center_value !== e.center || m_coord_index !== e.idx ||
                        m_status !== e.st || m_last_result !== e.last) begin
                        $display("%0t: mismatch exp c=%0d i=%0d s=%0d l=%0d act c=%0d i=%0d s=%0d l=%0d",
                                 $realtime, e.center, e.idx, e.st, e.last,
                                 $signed(m_center_value), m_coord_index, m_status,
                                 m_last_result);
                        errors++;
                    end
                end
                rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_q_value = '0;
        s_last_in_set = 1'b0;
        errors = 0;
        idle_cycles = 0;
        items_sent = 0;
        no_idle = 1'b0;
        vw_r = 5'd1;
        trim_r = 5'd0;
        iter_r = 16'd1;
        qmax_r = '1;
        store_full = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_rounding_and_trim();
        test_bound_and_overflow();
        test_bad_settings();
        test_long_iterations();
        test_random_sets();

        while (center_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: trimmed_centered_clip_aggregator_unit.f
rtl/core/tcca_pkg.sv
rtl/core/tcca_div.sv
rtl/core/tcca_dp.sv
rtl/core/tcca_ctrl.sv
rtl/core/trimmed_centered_clip_aggregator_unit.sv
bench/trimmed_centered_clip_aggregator_unit_tb.sv
